// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the biquad filter modules. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define BQD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression that must never be true outside reset
`define BQD_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BQD_ASSERT(lbl, clk, rst_n, prop, msg)
`define BQD_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ===== hw/rtl/bqd_pkg.sv =====
// ----------------------------------------------------------------------------
// bqd_pkg
// Types, widths and fixed-point helpers of the multichannel biquad filter.
// ----------------------------------------------------------------------------
package bqd_pkg;

    // channel count and state index width
    localparam int CHANNELS = 8;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // field widths
    localparam int SMP_W  = 24;
    localparam int CHAN_W = 3;
    localparam int COEF_W = 24;
    localparam int DLY_W  = 32;
    localparam int CFG_AW = 3;

    // internal arithmetic widths
    localparam int PROD_W = COEF_W + DLY_W;   // 24 x 32 signed product
    localparam int ACC_W  = 49;               // b0*x + r1*2^12
    localparam int NXT_W  = 60;               // delay update sums

    // coefficient reset values, Q3.20
    localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(1 << 20);
    localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;

    // rounding offsets and saturation limits
    localparam logic signed [ACC_W-1:0] ACC_RND20 = ACC_W'(64'd1 << 19);
    localparam logic signed [ACC_W-1:0] ACC_RND12 = ACC_W'(64'd1 << 11);
    localparam logic signed [NXT_W-1:0] NXT_RND20 = NXT_W'(64'd1 << 19);
    localparam logic signed [ACC_W-1:0] ACC_S24_MAX = ACC_W'(64'sd8388607);
    localparam logic signed [ACC_W-1:0] ACC_S24_MIN = ACC_W'(-64'sd8388608);
    localparam logic signed [ACC_W-1:0] ACC_S32_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] ACC_S32_MIN = ACC_W'(-64'sd2147483648);
    localparam logic signed [NXT_W-1:0] NXT_S32_MAX = NXT_W'(64'sd2147483647);
    localparam logic signed [NXT_W-1:0] NXT_S32_MIN = NXT_W'(-64'sd2147483648);

    // configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        CFG_FEED_FWD_0  = 3'd0,
        CFG_FEED_FWD_1  = 3'd1,
        CFG_FEED_FWD_2  = 3'd2,
        CFG_FEED_BACK_1 = 3'd3,
        CFG_FEED_BACK_2 = 3'd4
    } t_cfg_idx;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_B0,
        ST_MUL_B1,
        ST_MUL_B2,
        ST_MUL_A1,
        ST_MUL_A2,
        ST_FINISH,
        ST_WRITE
    } t_state;

    // operand pair of the shared multiplier
    typedef enum logic [2:0] {
        MUL_B0,
        MUL_B1,
        MUL_B2,
        MUL_A1,
        MUL_A2
    } t_mul_sel;

    // controller to datapath
    typedef struct packed {
        logic     load;      // capture request and channel state
        logic     mul_en;    // register a product
        t_mul_sel mul_sel;
        logic     acc_en;    // acc = b0*x + r1*2^12
        logic     y_en;      // round output and feedback, start n1
        logic     n2_init;   // start n2 from b2*x
        logic     n1_sub;    // n1 -= a1*y8
        logic     n2_sub;    // n2 -= a2*y8
        logic     write;     // store delays, load output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_blocked;   // output register full and not taken
    } t_dp_status;

    // round at bit 20 and clamp to signed 24 bits
    function automatic logic signed [SMP_W-1:0] sat24_rnd20(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] t;
        t = (v + ACC_RND20) >>> 20;
        if (t > ACC_S24_MAX) begin
            t = ACC_S24_MAX;
        end else if (t < ACC_S24_MIN) begin
            t = ACC_S24_MIN;
        end
        return t[SMP_W-1:0];
    endfunction

    // round at bit 12 and clamp to signed 32 bits
    function automatic logic signed [DLY_W-1:0] sat32_rnd12(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] t;
        t = (v + ACC_RND12) >>> 12;
        if (t > ACC_S32_MAX) begin
            t = ACC_S32_MAX;
        end else if (t < ACC_S32_MIN) begin
            t = ACC_S32_MIN;
        end
        return t[DLY_W-1:0];
    endfunction

    // round at bit 20 and clamp a delay update to signed 32 bits
    function automatic logic signed [DLY_W-1:0] sat32_rnd20(
        input logic signed [NXT_W-1:0] v
    );
        logic signed [NXT_W-1:0] t;
        t = (v + NXT_RND20) >>> 20;
        if (t > NXT_S32_MAX) begin
            t = NXT_S32_MAX;
        end else if (t < NXT_S32_MIN) begin
            t = NXT_S32_MIN;
        end
        return t[DLY_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/bqd_ctrl.sv =====
// ----------------------------------------------------------------------------
// bqd_ctrl
// Sequencer of the biquad: steps one request through the five products of
// the shared multiplier and the delay write-back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bqd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_accept,
    input  bqd_pkg::t_dp_status i_stat,
    output logic                o_in_ready,
    output bqd_pkg::t_dp_cmd    o_cmd
);
    import bqd_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_accept) begin
                    n_state = ST_MUL_B0;
                end
            end
            ST_MUL_B0: n_state = ST_MUL_B1;
            ST_MUL_B1: n_state = ST_MUL_B2;
            ST_MUL_B2: n_state = ST_MUL_A1;
            ST_MUL_A1: n_state = ST_MUL_A2;
            ST_MUL_A2: n_state = ST_FINISH;
            ST_FINISH: n_state = ST_WRITE;
            ST_WRITE: begin
                if (!i_stat.out_blocked) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_B0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_accept;
            end
            ST_MUL_B0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_B0;
            end
            ST_MUL_B1: begin
                o_cmd.acc_en  = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_B1;
            end
            ST_MUL_B2: begin
                o_cmd.y_en    = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_B2;
            end
            ST_MUL_A1: begin
                o_cmd.n2_init = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_A1;
            end
            ST_MUL_A2: begin
                o_cmd.n1_sub  = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_A2;
            end
            ST_FINISH: begin
                o_cmd.n2_sub = 1'b1;
            end
            ST_WRITE: begin
                o_cmd.write = !i_stat.out_blocked;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // checks
    `BQD_ASSERT(a_accept_starts, i_clk, i_rst_n, i_in_accept |=> r_state == ST_MUL_B0, "accepted request did not start the sequence")
    `BQD_NEVER(a_write_blocked, i_clk, i_rst_n, o_cmd.write && i_stat.out_blocked, "write-back while the output register is blocked")
    `BQD_ASSERT(a_one_phase, i_clk, i_rst_n, $onehot0({o_cmd.load, o_cmd.acc_en, o_cmd.y_en, o_cmd.n2_init, o_cmd.n1_sub, o_cmd.n2_sub, o_cmd.write}), "more than one datapath step in a cycle")

endmodule

// ===== hw/rtl/bqd_datapath.sv =====
// ----------------------------------------------------------------------------
// bqd_datapath
// Coefficient registers, per-channel delay state, one shared 24 x 32
// multiplier with its accumulators, and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bqd_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [bqd_pkg::CFG_AW-1:0]            i_cfg_addr,
    input  logic [bqd_pkg::COEF_W-1:0]            i_cfg_wdata,
    input  logic [bqd_pkg::SMP_W-1:0]             i_sample,
    input  logic [bqd_pkg::CHAN_W-1:0]            i_chan,
    input  bqd_pkg::t_dp_cmd                      i_cmd,
    output bqd_pkg::t_dp_status                   o_stat,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [bqd_pkg::SMP_W-1:0]             o_out_sample,
    output logic [bqd_pkg::CHAN_W-1:0]            o_out_chan
);
    import bqd_pkg::*;

    // coefficients
    logic signed [COEF_W-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;

    // per-channel delay state
    logic signed [DLY_W-1:0]  r_dly_one [CHANNELS];
    logic signed [DLY_W-1:0]  r_dly_two [CHANNELS];

    // working registers of the current request
    logic signed [SMP_W-1:0]  r_x;
    logic [CHAN_W-1:0]        r_ch;
    logic                     r_chan_ok;
    logic signed [DLY_W-1:0]  r_r1, r_r2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [SMP_W-1:0]  r_y;
    logic signed [DLY_W-1:0]  r_y8;
    logic signed [NXT_W-1:0]  r_n1, r_n2;

    // output register
    logic                     r_out_valid;
    logic [SMP_W-1:0]         r_out_sample;
    logic [CHAN_W-1:0]        r_out_chan;

    logic                     w_in_ok;
    logic [IDX_W-1:0]         w_in_idx;
    logic [IDX_W-1:0]         w_wr_idx;
    logic signed [COEF_W-1:0] w_mul_a;
    logic signed [DLY_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_prod;

    // coefficient writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= COEF_ONE;
            r_b1 <= COEF_ZERO;
            r_b2 <= COEF_ZERO;
            r_a1 <= COEF_ZERO;
            r_a2 <= COEF_ZERO;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FEED_FWD_0:  r_b0 <= i_cfg_wdata;
                CFG_FEED_FWD_1:  r_b1 <= i_cfg_wdata;
                CFG_FEED_FWD_2:  r_b2 <= i_cfg_wdata;
                CFG_FEED_BACK_1: r_a1 <= i_cfg_wdata;
                CFG_FEED_BACK_2: r_a2 <= i_cfg_wdata;
                default: begin
                    r_b0 <= r_b0;
                end
            endcase
        end
    end

    // channel decode
    assign w_in_ok  = int'(i_chan) < CHANNELS;
    assign w_in_idx = IDX_W'(i_chan);
    assign w_wr_idx = IDX_W'(r_ch);

    // capture request, channels out of range run with zero state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x       <= i_sample;
            r_ch      <= i_chan;
            r_chan_ok <= w_in_ok;
            r_r1      <= w_in_ok ? r_dly_one[w_in_idx] : '0;
            r_r2      <= w_in_ok ? r_dly_two[w_in_idx] : '0;
        end
    end

    // shared multiplier operand select
    always_comb begin
        w_mul_a = r_b0;
        w_mul_b = DLY_W'(r_x);
        case (i_cmd.mul_sel)
            MUL_B0: w_mul_a = r_b0;
            MUL_B1: w_mul_a = r_b1;
            MUL_B2: w_mul_a = r_b2;
            MUL_A1: begin
                w_mul_a = r_a1;
                w_mul_b = r_y8;
            end
            MUL_A2: begin
                w_mul_a = r_a2;
                w_mul_b = r_y8;
            end
            default: w_mul_a = r_b0;
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // product register and accumulation steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.acc_en) begin
            r_acc <= ACC_W'(r_prod) + (ACC_W'(r_r1) <<< 12);
        end
        if (i_cmd.y_en) begin
            r_y  <= sat24_rnd20(r_acc);
            r_y8 <= sat32_rnd12(r_acc);
            r_n1 <= (NXT_W'(r_prod) <<< 8) + (NXT_W'(r_r2) <<< 20);
        end
        if (i_cmd.n2_init) begin
            r_n2 <= NXT_W'(r_prod) <<< 8;
        end
        if (i_cmd.n1_sub) begin
            r_n1 <= r_n1 - NXT_W'(r_prod);
        end
        if (i_cmd.n2_sub) begin
            r_n2 <= r_n2 - NXT_W'(r_prod);
        end
    end

    // delay state write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_dly_one[i] <= '0;
                r_dly_two[i] <= '0;
            end
        end else if (i_cmd.write && r_chan_ok) begin
            r_dly_one[w_wr_idx] <= sat32_rnd20(r_n1);
            r_dly_two[w_wr_idx] <= sat32_rnd20(r_n2);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.write) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_out_sample <= r_y;
            r_out_chan   <= r_ch;
        end
    end

    assign o_stat.out_blocked = r_out_valid && !i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out_sample       = r_out_sample;
    assign o_out_chan         = r_out_chan;

    // checks
    `BQD_ASSERT(a_write_shows, i_clk, i_rst_n, i_cmd.write |=> r_out_valid, "write-back did not present a result")
    `BQD_ASSERT(a_stall_holds, i_clk, i_rst_n, (r_out_valid && !i_out_ready) |=> r_out_valid && $stable(r_out_sample), "stalled result changed")

endmodule

// ===== hw/rtl/biquad_tdf2_multichannel.sv =====
// ----------------------------------------------------------------------------
// biquad_tdf2_multichannel
// Second-order IIR section, transposed direct form II, time-shared by up to
// eight audio channels with one delay pair per channel.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests arrive on s_axis_*: tdata holds the signed 24-bit sample,
//   tuser the 3-bit channel number. Results leave on m_axis_* in the same
//   layout, one per input, in order, with the channel echoed.
//   Coefficients b0, b1, b2, a1, a2 (signed Q3.20) are written through
//   i_cfg_we / i_cfg_addr / i_cfg_wdata while the block is idle.
//   A request steps through the accept, five products on the single
//   shared 24 x 32 multiplier, one final subtract and the write-back. The
//   result shows on m_axis_tvalid after the write-back, and a new request
//   is taken only once the previous one has been written back.
//   The output register holds a finished result while the next request is
//   being worked on; if the receiver still stalls at write-back time, the
//   sequence waits there and s_axis_tready stays low.
//   Channel numbers at or beyond the channel count are filtered from zero
//   state and leave no state behind.
//   Reset clears all delay state, sets b0 = 1.0 and the other coefficients
//   to zero, and empties the output register.
// ----------------------------------------------------------------------------
module biquad_tdf2_multichannel (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [bqd_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  logic [bqd_pkg::COEF_W-1:0]        i_cfg_wdata,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [23:0]                       s_axis_tdata,   // [23:0] sample_in
    input  logic [2:0]                        s_axis_tuser,   // [2:0] chan_in
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [23:0]                       m_axis_tdata,   // [23:0] sample_out
    output logic [2:0]                        m_axis_tuser    // [2:0] chan_out
);
    import bqd_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_stat;
    logic       w_in_ready;
    logic       w_in_accept;

    assign w_in_accept   = s_axis_tvalid && w_in_ready;
    assign s_axis_tready = w_in_ready;

    // sequencer
    bqd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (w_in_accept),
        .i_stat      (w_stat),
        .o_in_ready  (w_in_ready),
        .o_cmd       (w_cmd)
    );

    // arithmetic and state
    bqd_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_sample     (s_axis_tdata),
        .i_chan       (s_axis_tuser),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_sample (m_axis_tdata),
        .o_out_chan   (m_axis_tuser)
    );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multichannel transposed direct form II biquad.
// Requests go in on the s_axis stream and a bit-exact fixed point model of
// the filter predicts every result. Results on the m_axis stream are checked
// in order, sample and channel. Coefficients are loaded between phases while
// the block is idle. Both stream sides idle at random, and one long receiver
// stall backs the block up.
// ----------------------------------------------------------------------------
module testbench;
    import bqd_pkg::*;

    localparam int     NUM_COEFS    = 5;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     QUIET_LIMIT  = 4000;
    localparam int     DRAIN_CYCLES = 16;
    localparam int     BLOCK_ITEMS  = 100;
    localparam int     PHASE_ITEMS  = 600;
    localparam longint OUT_MAX      = 64'sd8388607;
    localparam longint OUT_MIN      = -64'sd8388608;
    localparam longint DLY_MAX      = 64'sd2147483647;
    localparam longint DLY_MIN      = -64'sd2147483648;
    localparam logic [SMP_W-1:0]  SMP_MAX  = 24'h7FFFFF;
    localparam logic [SMP_W-1:0]  SMP_MIN  = 24'h800000;
    localparam logic [COEF_W-1:0] COEF_MAX = 24'h7FFFFF;
    localparam logic [COEF_W-1:0] COEF_MIN = 24'h800000;
    localparam logic [COEF_W-1:0] COEF_HALF = 24'h080000;

    // how a random coefficient set is drawn
    typedef enum int {
        STYLE_FULL,
        STYLE_MILD,
        STYLE_EDGE
    } t_coef_style;

    typedef struct packed {
        logic [SMP_W-1:0]  sample;
        logic [CHAN_W-1:0] chan;
    } t_audio_item;

    typedef logic [NUM_COEFS-1:0][COEF_W-1:0] t_coef_set;

    // block ports
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0]    i_cfg_addr    = '0;
    logic [COEF_W-1:0]    i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata  = '0;   // [23:0] sample_in
    logic [2:0]           s_axis_tuser  = '0;   // [2:0] chan_in
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;         // [23:0] sample_out
    logic [2:0]           m_axis_tuser;         // [2:0] chan_out

    // filter model state
    logic signed [COEF_W-1:0] coef_q [NUM_COEFS];
    logic signed [DLY_W-1:0]  chan_delay1 [CHANNELS];
    logic signed [DLY_W-1:0]  chan_delay2 [CHANNELS];
    t_audio_item              filtered_q [$];

    // run bookkeeping
    int  mismatches    = 0;
    int  requests_sent = 0;
    int  results_seen  = 0;
    int  quiet_cycles  = 0;
    int  tx_idle_pct   = 0;
    int  rx_idle_pct   = 0;
    int  hold_left     = 0;
    bit  hold_request  = 1'b0;

    biquad_tdf2_multichannel dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // round half toward +infinity at bit s
    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_to(input longint v, input longint lo,
                                        input longint hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // one filter step for the request's channel, updates that channel's delays
    function automatic t_audio_item filter_sample(input t_audio_item req);
        longint      x, r1, r2, b0, b1, b2, a1, a2;
        longint      acc, y, y8, n1, n2;
        bit          known_chan;
        t_audio_item res;
        x  = longint'(signed'(req.sample));
        b0 = coef_q[CFG_FEED_FWD_0];
        b1 = coef_q[CFG_FEED_FWD_1];
        b2 = coef_q[CFG_FEED_FWD_2];
        a1 = coef_q[CFG_FEED_BACK_1];
        a2 = coef_q[CFG_FEED_BACK_2];
        known_chan = (int'(req.chan) < CHANNELS);
        r1 = 0;
        r2 = 0;
        if (known_chan) begin
            r1 = chan_delay1[req.chan];
            r2 = chan_delay2[req.chan];
        end
        acc = b0 * x + r1 * 4096;
        y   = clamp_to(round_half_up(acc, 20), OUT_MIN, OUT_MAX);
        y8  = clamp_to(round_half_up(acc, 12), DLY_MIN, DLY_MAX);
        n1  = b1 * x * 256 - a1 * y8 + r2 * 1048576;
        n2  = b2 * x * 256 - a2 * y8;
        // channels past the count leave no state behind
        if (known_chan) begin
            chan_delay1[req.chan] = DLY_W'(clamp_to(round_half_up(n1, 20), DLY_MIN, DLY_MAX));
            chan_delay2[req.chan] = DLY_W'(clamp_to(round_half_up(n2, 20), DLY_MIN, DLY_MAX));
        end
        res.sample = y[SMP_W-1:0];
        res.chan   = req.chan;
        return res;
    endfunction

    // model update on config writes and requests, result check
    always @(posedge i_clk) begin : monitor
        t_audio_item req;
        t_audio_item want;
        if (!i_rst_n) begin
            coef_q[CFG_FEED_FWD_0]  = COEF_ONE;
            coef_q[CFG_FEED_FWD_1]  = COEF_ZERO;
            coef_q[CFG_FEED_FWD_2]  = COEF_ZERO;
            coef_q[CFG_FEED_BACK_1] = COEF_ZERO;
            coef_q[CFG_FEED_BACK_2] = COEF_ZERO;
            for (int c = 0; c < CHANNELS; c++) begin
                chan_delay1[c] = '0;
                chan_delay2[c] = '0;
            end
        end else begin
            if (i_cfg_we && i_cfg_addr <= CFG_FEED_BACK_2) begin
                coef_q[i_cfg_addr] = i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                req.sample = s_axis_tdata;
                req.chan   = s_axis_tuser;
                filtered_q.push_back(filter_sample(req));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (filtered_q.size() == 0) begin
                    $error("unexpected result: sample_out %0d chan_out %0d",
                           $signed(m_axis_tdata), m_axis_tuser);
                    mismatches++;
                end else begin
                    want = filtered_q.pop_front();
                    if (m_axis_tdata !== want.sample) begin
                        $error("sample_out: expected %0d, got %0d",
                               $signed(want.sample), $signed(m_axis_tdata));
                        mismatches++;
                    end
                    if (m_axis_tuser !== want.chan) begin
                        $error("chan_out: expected %0d, got %0d", want.chan, m_axis_tuser);
                        mismatches++;
                    end
                end
            end
        end
    end

    // receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_we || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // offer one request, with random gaps ahead of it
    task automatic send_sample(input logic [SMP_W-1:0] sample, input logic [CHAN_W-1:0] chan);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        s_axis_tuser  <= chan;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        requests_sent++;
    endtask

    // stop sending and wait until every result is back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (results_seen < requests_sent) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write all coefficients, then junk to the unused indexes
    task automatic load_coefs(input t_coef_set c);
        for (int i = CFG_FEED_FWD_0; i <= CFG_FEED_BACK_2; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= CFG_AW'(i);
            i_cfg_wdata <= c[i];
            @(posedge i_clk);
        end
        // writes past the last register must be ignored
        for (int i = CFG_FEED_BACK_2 + 1; i < (1 << CFG_AW); i++) begin
            i_cfg_addr  <= CFG_AW'(i);
            i_cfg_wdata <= COEF_W'($urandom());
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [COEF_W-1:0] pick_coef(input t_coef_style style);
        case (style)
            STYLE_FULL: begin
                return COEF_W'($urandom());
            end
            STYLE_MILD: begin
                return COEF_W'(int'($urandom_range(1 << 22)) - (1 << 21));
            end
            default: begin
                case ($urandom_range(3))
                    0: return COEF_MAX;
                    1: return COEF_MIN;
                    2: return COEF_ZERO;
                    default: return COEF_ONE;
                endcase
            end
        endcase
    endfunction

    function automatic logic [SMP_W-1:0] pick_sample();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(3))
                    0: return SMP_MAX;
                    1: return SMP_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2: begin
                return SMP_W'(int'($urandom_range(2048)) - 1024);
            end
            default: begin
                return SMP_W'($urandom());
            end
        endcase
    endfunction

    // reset coefficients give a straight pass-through on every channel
    task automatic test_reset_defaults();
        logic [SMP_W-1:0] edge_vals [8];
        edge_vals = '{SMP_MAX, SMP_MIN, 24'h000000, 24'hFFFFFF,
                      24'h000001, 24'h555555, 24'hAAAAAA, 24'h123456};
        for (int c = 0; c < 8; c++) begin
            send_sample(edge_vals[c], CHAN_W'(c));
        end
        wait_idle();
    endtask

    // largest coefficients drive output and delays into saturation
    task automatic test_saturation();
        t_coef_set c;
        c[CFG_FEED_FWD_0]  = COEF_MAX;
        c[CFG_FEED_FWD_1]  = COEF_MAX;
        c[CFG_FEED_FWD_2]  = COEF_MIN;
        c[CFG_FEED_BACK_1] = COEF_MIN;
        c[CFG_FEED_BACK_2] = COEF_MAX;
        load_coefs(c);
        send_sample(SMP_MAX, 3'd0);
        send_sample(SMP_MAX, 3'd0);
        send_sample(SMP_MIN, 3'd0);
        send_sample(SMP_MIN, 3'd1);
        send_sample(SMP_MIN, 3'd1);
        send_sample(SMP_MAX, 3'd1);
        send_sample(24'h000000, 3'd0);
        send_sample(24'h000000, 3'd1);
        wait_idle();
    endtask

    // halves round toward +infinity in output and delay updates
    task automatic test_rounding();
        t_coef_set c;
        c[CFG_FEED_FWD_0]  = COEF_HALF;
        c[CFG_FEED_FWD_1]  = COEF_HALF;
        c[CFG_FEED_FWD_2]  = COEF_ZERO;
        c[CFG_FEED_BACK_1] = COEF_ZERO;
        c[CFG_FEED_BACK_2] = COEF_HALF;
        load_coefs(c);
        send_sample(24'h000001, 3'd2);
        send_sample(24'hFFFFFF, 3'd2);
        send_sample(24'h000003, 3'd2);
        send_sample(24'hFFFFFD, 3'd2);
        send_sample(24'h000000, 3'd2);
        send_sample(24'h000000, 3'd2);
        wait_idle();
    endtask

    // random coefficient sets, each followed by a block of random requests
    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        t_coef_set   c;
        t_coef_style style;
        int          pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < count; n += BLOCK_ITEMS) begin
            pick  = $urandom_range(9);
            style = (pick < 6) ? STYLE_MILD : (pick < 8) ? STYLE_FULL : STYLE_EDGE;
            for (int i = CFG_FEED_FWD_0; i <= CFG_FEED_BACK_2; i++) begin
                c[i] = pick_coef(style);
            end
            load_coefs(c);
            for (int k = 0; k < BLOCK_ITEMS; k++) begin
                send_sample(pick_sample(), CHAN_W'($urandom_range(CHANNELS - 1)));
            end
            wait_idle();
        end
    endtask

    // long receiver stall while the sender keeps offering requests
    task automatic test_output_hold();
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = 1'b1;
        for (int k = 0; k < 40; k++) begin
            send_sample(pick_sample(), CHAN_W'($urandom_range(CHANNELS - 1)));
        end
        wait_idle();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_saturation();
        test_rounding();
        test_random_traffic(21, 64, PHASE_ITEMS);
        test_random_traffic(64, 21, PHASE_ITEMS);
        test_random_traffic(0, 0, PHASE_ITEMS);
        test_output_hold();

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
